// File: rtl/core/detector_hit_layer_tally_core_assert.svh
// Assertion macros for the checker file of the hit layer tally core.
// Each macro expects a clock named i_clk; DHLT_ASSERT also expects an active-low reset named i_rst_n.
`ifndef DETECTOR_HIT_LAYER_TALLY_CORE_ASSERT_SVH
`define DETECTOR_HIT_LAYER_TALLY_CORE_ASSERT_SVH

// Clocked assertion, off while reset is held.
`define DHLT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Clocked assertion that also checks across reset.
`define DHLT_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// File: rtl/core/dhlt_pkg.sv
// Package of the hit layer tally core: sizes, codes, types and saturating helpers.
// Used by every design module of rtl/core except the checker; depends on nothing.
`timescale 1ns / 1ps

package dhlt_pkg;

    localparam int TABLE_DEPTH  = 64;
    localparam int REGION_CODES = 8;
    localparam int COUNT_WIDTH  = 16;

    localparam int ADDR_W = $clog2(TABLE_DEPTH);
    localparam int FILL_W = $clog2(TABLE_DEPTH + 1);
    localparam int REG_W  = (REGION_CODES > 1) ? $clog2(REGION_CODES) : 1;

    // Function codes of an input item
    localparam logic FUNC_ADD   = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    // Configuration register indexes
    localparam logic [1:0] CFG_FLAT_MASK  = 2'd0;
    localparam logic [1:0] CFG_PIXEL_MASK = 2'd1;
    localparam logic [1:0] CFG_STRIP_MASK = 2'd2;

    // Configuration reset values
    localparam logic [7:0] FLAT_MASK_RST  = 8'd9;
    localparam logic [7:0] PIXEL_MASK_RST = 8'd7;
    localparam logic [7:0] STRIP_MASK_RST = 8'd24;

    localparam logic [7:0] LAYER_CNT_MAX = 8'hFF;

    typedef logic [COUNT_WIDTH-1:0] t_cnt;

    // One row of the table
    typedef struct packed {
        logic [2:0] region;
        logic [5:0] layer;
        logic [7:0] layer_cnt;
        t_cnt       hits;
    } t_row;

    // Update of one region's running sums
    typedef struct packed {
        logic             en;
        logic [REG_W-1:0] region;
        logic [3:0]       hit_add;
        logic             lay_inc;
    } t_sum_upd;

    // Sums collected by one sweep over the regions
    typedef struct packed {
        t_cnt total_hits;
        t_cnt total_layers;
        t_cnt pixel_hits;
        t_cnt pixel_layers;
        t_cnt strip_hits;
        t_cnt strip_layers;
    } t_totals;

    function automatic t_cnt sat_add(input t_cnt a, input t_cnt b);
        logic [COUNT_WIDTH:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[COUNT_WIDTH] ? {COUNT_WIDTH{1'b1}} : s[COUNT_WIDTH-1:0];
    endfunction

    // Clip a counter to a 16-bit output field
    function automatic logic [15:0] clip16(input t_cnt v);
        logic [COUNT_WIDTH+16:0] w;
        w = (COUNT_WIDTH+17)'(v);
        return (w > (COUNT_WIDTH+17)'(16'hFFFF)) ? 16'hFFFF : w[15:0];
    endfunction

endpackage

// File: rtl/core/dhlt_row_ram.sv
// Row table memory: one write port, one read port with registered read data.
// Depends on dhlt_pkg for the row type and depth.
`timescale 1ns / 1ps

module dhlt_row_ram import dhlt_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output t_row              o_rd_data,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  t_row              i_wr_data
);

    t_row r_mem [TABLE_DEPTH];
    t_row r_rd_data;

    // Write and read the row array
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: rtl/core/dhlt_region_bank.sv
// Per-region hit and layer sums, with a sweep that forms total, pixel and strip sums.
// Depends on dhlt_pkg for sizes, types and the saturating add.
`timescale 1ns / 1ps

module dhlt_region_bank import dhlt_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_sum_upd         i_upd,
    input  logic [REG_W-1:0] i_rd_region,
    output t_cnt             o_rd_hits,
    output t_cnt             o_rd_layers,
    input  logic             i_sweep_start,
    input  logic [7:0]       i_pixel_mask,
    input  logic [7:0]       i_strip_mask,
    output logic             o_sweep_done,
    output t_totals          o_totals
);

    localparam logic [REG_W-1:0] LAST_REGION = REG_W'(REGION_CODES - 1);

    t_cnt             r_hit_sum [REGION_CODES];
    t_cnt             r_lay_sum [REGION_CODES];
    logic             r_busy;
    logic             r_done;
    logic [REG_W-1:0] r_cnt;
    t_totals          r_acc;

    logic [4:0] cnt_ext;
    logic       in_pixel;
    logic       in_strip;

    // Class membership of the region under the sweep
    always_comb begin
        cnt_ext  = 5'(r_cnt);
        in_pixel = (cnt_ext < 5'd8) && i_pixel_mask[cnt_ext[2:0]];
        in_strip = (cnt_ext < 5'd8) && i_strip_mask[cnt_ext[2:0]];
    end

    // Apply a region update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < REGION_CODES; r++) begin
                r_hit_sum[r] <= '0;
                r_lay_sum[r] <= '0;
            end
        end else if (i_upd.en) begin
            r_hit_sum[i_upd.region] <= sat_add(r_hit_sum[i_upd.region],
                                               COUNT_WIDTH'(i_upd.hit_add));
            if (i_upd.lay_inc) begin
                r_lay_sum[i_upd.region] <= sat_add(r_lay_sum[i_upd.region],
                                                   COUNT_WIDTH'(1));
            end
        end
    end

    // Walk the regions one per cycle and accumulate the group sums
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_sweep_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (r_cnt == LAST_REGION) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_sweep_start) begin
            r_acc <= '0;
        end else if (r_busy) begin
            r_acc.total_hits   <= sat_add(r_acc.total_hits, r_hit_sum[r_cnt]);
            r_acc.total_layers <= sat_add(r_acc.total_layers, r_lay_sum[r_cnt]);
            if (in_pixel) begin
                r_acc.pixel_hits   <= sat_add(r_acc.pixel_hits, r_hit_sum[r_cnt]);
                r_acc.pixel_layers <= sat_add(r_acc.pixel_layers, r_lay_sum[r_cnt]);
            end
            if (in_strip) begin
                r_acc.strip_hits   <= sat_add(r_acc.strip_hits, r_hit_sum[r_cnt]);
                r_acc.strip_layers <= sat_add(r_acc.strip_layers, r_lay_sum[r_cnt]);
            end
        end
    end

    assign o_rd_hits    = r_hit_sum[i_rd_region];
    assign o_rd_layers  = r_lay_sum[i_rd_region];
    assign o_sweep_done = r_done;
    assign o_totals     = r_acc;

endmodule

// File: rtl/core/detector_hit_layer_tally_core.sv
// Top level of the hit layer tally core: input capture, row scan sequencer, update
// and result register. Depends on dhlt_pkg, dhlt_row_ram and dhlt_region_bank.
`timescale 1ns / 1ps
//
// Usage
//   Input items arrive on the s_ stream (tdata: region, layer, eta_idx, hit_count;
//   tuser: func). Each item gives exactly one result item on the m_ stream (tdata:
//   row, region, total, pixel and strip counts; tuser: table_full).
//   Registers are written over the cfg channel (index 0 flat mask, 1 pixel mask,
//   2 strip mask); cfg_ready is always high, writes are meant for idle periods.
//   One item is worked at a time; the next item is accepted only once the last
//   has gone to the output register. From acceptance to its result, the key scan
//   reads the row memory one row per cycle over the rows in use until a match,
//   then an add writes the row back (on a match or with room in the table)
//   and the region sums are swept for the totals.
//   An item whose region code is out of range skips the scan and the write.
//   The result waits in an output register; a stalled receiver holds it there,
//   and the next item is accepted and worked meanwhile, finishing only once the
//   register is free.
//   Reset clears the row fill count, the region sums and the last eta, and loads
//   the mask reset values. The row memory itself needs no clearing pass: rows
//   at or beyond the fill count are never read.

module detector_hit_layer_tally_core import dhlt_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // cfg write channel
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [1:0]   i_cfg_index,
    input  logic [7:0]   i_cfg_data,
    // input items
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [23:0]  s_tdata,  // region[2:0], layer[8:3], eta_idx[16:9],
                                   // hit_count[20:17], zero[23:21]
    input  logic         s_tuser,  // func
    // result items
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [151:0] m_tdata,  // row_hits[15:0], row_layers[23:16],
                                   // region_hits[39:24], region_layers[55:40],
                                   // total_hits[71:56], total_layers[87:72],
                                   // pixel_hits[103:88], pixel_layers[119:104],
                                   // strip_hits[135:120], strip_layers[151:136]
    output logic         m_tuser   // table_full
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_UPD   = 3'd2;
    localparam logic [2:0] S_SWEEP = 3'd3;
    localparam logic [2:0] S_OUT   = 3'd4;

    logic [2:0]        r_state, n_state;
    logic [7:0]        r_flat_mask, r_pixel_mask, r_strip_mask;
    logic [7:0]        r_last_eta;
    logic [FILL_W-1:0] r_used;
    logic [FILL_W-1:0] r_idx;
    logic              r_pend;
    logic [ADDR_W-1:0] r_pidx;
    logic              r_found;
    logic [ADDR_W-1:0] r_midx;
    t_row              r_row;

    logic              r_func;
    logic [2:0]        r_region;
    logic [5:0]        r_layer;
    logic [7:0]        r_eta;
    logic [3:0]        r_hits;
    logic              r_ok;

    logic [15:0]       r_row_hits;
    logic [7:0]        r_row_layers;
    logic              r_full;

    logic              r_mvalid;
    logic [151:0]      r_mdata;
    logic              r_muser;

    logic              s_accept;
    logic              in_ok;
    logic              rd_en;
    t_row              rd_data;
    logic              scan_hit;
    logic              scan_miss;
    logic              room;
    logic              do_add;
    logic              eta_inc;
    t_cnt              new_hits;
    logic [7:0]        new_lc;
    t_row              wr_data;
    logic [ADDR_W-1:0] wr_addr;
    t_sum_upd          sum_upd;
    logic [REG_W-1:0]  reg_idx;
    t_cnt              reg_hits, reg_layers;
    logic              sweep_start;
    logic              sweep_done;
    t_totals           totals;
    logic              out_free;

    assign o_cfg_ready = 1'b1;
    assign s_tready    = (r_state == S_IDLE);
    assign s_accept    = s_tvalid && s_tready;
    assign in_ok       = (5'(s_tdata[2:0]) < 5'(REGION_CODES));
    assign out_free    = !r_mvalid || m_tready;

    // Scan control: one row read per cycle, compared in the cycle after its read
    assign scan_hit  = r_pend && (rd_data.region == r_region) && (rd_data.layer == r_layer);
    assign scan_miss = !r_pend && (r_idx >= r_used);
    assign rd_en     = (r_state == S_SCAN) && (r_idx < r_used) && !scan_hit;

    // Row update values
    always_comb begin
        room     = (r_used < FILL_W'(TABLE_DEPTH));
        do_add   = (r_state == S_UPD) && (r_func == FUNC_ADD) && (r_found || room);
        eta_inc  = !r_flat_mask[r_region] && (r_eta != r_last_eta);
        new_hits = sat_add(r_row.hits, COUNT_WIDTH'(r_hits));
        new_lc   = (eta_inc && (r_row.layer_cnt != LAYER_CNT_MAX)) ?
                   r_row.layer_cnt + 8'd1 : r_row.layer_cnt;

        wr_data.region = r_region;
        wr_data.layer  = r_layer;
        if (r_found) begin
            wr_data.layer_cnt = new_lc;
            wr_data.hits      = new_hits;
            wr_addr           = r_midx;
        end else begin
            wr_data.layer_cnt = 8'd1;
            wr_data.hits      = COUNT_WIDTH'(r_hits);
            wr_addr           = r_used[ADDR_W-1:0];
        end

        reg_idx        = REG_W'(r_region);
        sum_upd.en     = do_add;
        sum_upd.region = reg_idx;
        sum_upd.hit_add = r_found ? 4'(new_hits - r_row.hits) : r_hits;
        sum_upd.lay_inc = r_found ? (new_lc != r_row.layer_cnt) : 1'b1;
    end

    assign sweep_start = (r_state == S_UPD) || (s_accept && !in_ok);

    // Sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (s_accept) begin
                    n_state = in_ok ? S_SCAN : S_SWEEP;
                end
            end
            S_SCAN: begin
                if (scan_hit || scan_miss) begin
                    n_state = S_UPD;
                end
            end
            S_UPD:   n_state = S_SWEEP;
            S_SWEEP: begin
                if (sweep_done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_flat_mask  <= FLAT_MASK_RST;
            r_pixel_mask <= PIXEL_MASK_RST;
            r_strip_mask <= STRIP_MASK_RST;
            r_last_eta   <= '0;
            r_used       <= '0;
            r_idx        <= '0;
            r_pend       <= 1'b0;
            r_found      <= 1'b0;
            r_mvalid     <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_FLAT_MASK:  r_flat_mask  <= i_cfg_data;
                    CFG_PIXEL_MASK: r_pixel_mask <= i_cfg_data;
                    CFG_STRIP_MASK: r_strip_mask <= i_cfg_data;
                    default: ;
                endcase
            end
            if (s_accept) begin
                r_idx   <= '0;
                r_pend  <= 1'b0;
                r_found <= 1'b0;
            end else if (r_state == S_SCAN) begin
                r_pend <= rd_en;
                if (rd_en) begin
                    r_idx <= r_idx + 1'b1;
                end
                if (scan_hit) begin
                    r_found <= 1'b1;
                end
            end
            if (do_add) begin
                if (!r_found) begin
                    r_used     <= r_used + 1'b1;
                    r_last_eta <= r_eta;
                end else if (eta_inc) begin
                    r_last_eta <= r_eta;
                end
            end
            if (r_state == S_OUT && out_free) begin
                r_mvalid <= 1'b1;
            end else if (m_tready) begin
                r_mvalid <= 1'b0;
            end
        end
    end

    // Payload: captured item, matched row, report values, result register
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_func   <= s_tuser;
            r_region <= s_tdata[2:0];
            r_layer  <= s_tdata[8:3];
            r_eta    <= s_tdata[16:9];
            r_hits   <= s_tdata[20:17];
            r_ok     <= in_ok;
            r_row_hits   <= '0;
            r_row_layers <= '0;
            r_full       <= 1'b0;
        end
        if (r_state == S_SCAN) begin
            r_pidx <= r_idx[ADDR_W-1:0];
            if (scan_hit) begin
                r_row  <= rd_data;
                r_midx <= r_pidx;
            end
        end
        if (r_state == S_UPD) begin
            if (r_found) begin
                r_row_hits   <= clip16((r_func == FUNC_ADD) ? new_hits : r_row.hits);
                r_row_layers <= (r_func == FUNC_ADD) ? new_lc : r_row.layer_cnt;
            end else if (do_add) begin
                r_row_hits   <= clip16(COUNT_WIDTH'(r_hits));
                r_row_layers <= 8'd1;
            end
            r_full <= (r_func == FUNC_ADD) && !r_found && !room;
        end
        if (r_state == S_OUT && out_free) begin
            r_mdata[15:0]    <= r_row_hits;
            r_mdata[23:16]   <= r_row_layers;
            r_mdata[39:24]   <= r_ok ? clip16(reg_hits) : 16'd0;
            r_mdata[55:40]   <= r_ok ? clip16(reg_layers) : 16'd0;
            r_mdata[71:56]   <= clip16(totals.total_hits);
            r_mdata[87:72]   <= clip16(totals.total_layers);
            r_mdata[103:88]  <= clip16(totals.pixel_hits);
            r_mdata[119:104] <= clip16(totals.pixel_layers);
            r_mdata[135:120] <= clip16(totals.strip_hits);
            r_mdata[151:136] <= clip16(totals.strip_layers);
            r_muser          <= r_full;
        end
    end

    dhlt_row_ram u_row_ram (
        .i_clk     (i_clk),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_idx[ADDR_W-1:0]),
        .o_rd_data (rd_data),
        .i_wr_en   (do_add),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data)
    );

    dhlt_region_bank u_region_bank (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_upd         (sum_upd),
        .i_rd_region   (reg_idx),
        .o_rd_hits     (reg_hits),
        .o_rd_layers   (reg_layers),
        .i_sweep_start (sweep_start),
        .i_pixel_mask  (r_pixel_mask),
        .i_strip_mask  (r_strip_mask),
        .o_sweep_done  (sweep_done),
        .o_totals      (totals)
    );

    assign m_tvalid = r_mvalid;
    assign m_tdata  = r_mdata;
    assign m_tuser  = r_muser;

endmodule

// File: rtl/core/dhlt_checker.sv
// Port-level checks of the hit layer tally core, bound to the top level.
// Depends on detector_hit_layer_tally_core_assert.svh for the assertion macros.
`timescale 1ns / 1ps
`include "detector_hit_layer_tally_core_assert.svh"

module dhlt_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [151:0] m_tdata,   // row, region, total, pixel, strip counts
    input logic         m_tuser    // table_full
);

    // No result right after reset
    `DHLT_ASSERT_RST(a_rst_no_result, !i_rst_n |=> !m_tvalid, "result valid after reset")

    // Hold a stalled result
    `DHLT_ASSERT(a_stall_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

    // Work one item at a time
    `DHLT_ASSERT(a_one_item, s_tvalid && s_tready |=> !s_tready, "item accepted while busy")

    // A full table reports an empty row
    `DHLT_ASSERT(a_full_row_zero, m_tvalid && m_tuser |-> m_tdata[23:0] == 24'd0, "full with row counts")

    // Row hits fit in the region sum, the region sum in the total
    `DHLT_ASSERT(a_sum_order, m_tvalid |-> m_tdata[15:0] <= m_tdata[39:24] && m_tdata[39:24] <= m_tdata[71:56], "row, region and total hits out of order")

endmodule

bind detector_hit_layer_tally_core dhlt_checker u_dhlt_checker (.*);
